FILE: design/tgd_pkg.sv
// tgd_pkg: shared types, codes and default constants of the tile group dispatcher.
// No dependencies; imported by tgd_front, tgd_back, tile_group_dispatcher and the testbench.
package tgd_pkg;

	// default sizes, handed to the top-level parameters
	localparam int MAX_PASSES_DEF = 16;
	localparam int TILE_BITS_DEF  = 16;

	// running group totals saturate at this width
	localparam int GROUP_BITS = 20;
	localparam logic [GROUP_BITS-1:0] GROUP_MAX = {GROUP_BITS{1'b1}};

	// command queue between front and back (power of two)
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	// APB register map, word addressed
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_TILE_COUNT = 2'd0;
	localparam logic [1:0] REG_PASS_COUNT = 2'd1;
	localparam logic [1:0] REG_CLAMP_PASS = 2'd2;

	// raw command codes on the input channel
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_REQUEST = 2'd2;

	// decoded operation carried through the queue
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTART = 2'd1,
		OP_REQUEST = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] group_tiles;
		logic [3:0] coarse_pass;
	} cmd_t;

	typedef struct packed {
		logic [QCW-1:0] count;
	} front_status_t;

endpackage

FILE: design/tgd_ram.sv
// tgd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/tgd_div.sv
// tgd_div: iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; divisor must be nonzero. done is set at the edge that registers the last step.
module tgd_div #(
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic [DW:0]     rem_q;
	logic [DW-1:0]   quo_q;
	logic [DW-1:0]   div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic [DW+1:0]   diff;
	logic            ge;

	// shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, div_q};
		ge     = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW:0] : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/tgd_front.sv
// tgd_front: accepts command beats, decodes them and queues them for the back end.
// Depends on tgd_pkg.
module tgd_front import tgd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    command,
	input  logic [7:0]    group_tiles,
	input  logic [3:0]    coarse_pass,
	output cmd_t          q_head,
	output logic          q_valid,
	input  logic          q_pop,
	output front_status_t status
);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	cmd_t           entry;
	logic           push;
	logic           pop;

	// classify the raw command
	always_comb begin
		entry.group_tiles = group_tiles;
		entry.coarse_pass = coarse_pass;
		case (command)
			CMD_LOAD:    entry.op = OP_LOAD;
			CMD_RESTART: entry.op = OP_RESTART;
			CMD_REQUEST: entry.op = OP_REQUEST;
			default:     entry.op = OP_NOP;
		endcase
	end

	assign in_stall = (count_q == QCW'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_head   = slot_q[rd_ptr_q];

	assign status.count = count_q;

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

endmodule

FILE: design/tgd_back.sv
// tgd_back: executes queued commands: pass table loads, restarts and group requests.
// Depends on tgd_pkg, tgd_ram (pass tables) and tgd_div (shared divider).
module tgd_back import tgd_pkg::*; #(
	parameter int MAX_PASSES = MAX_PASSES_DEF,
	parameter int TILE_BITS  = TILE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TILE_BITS-1:0] tile_count,
	input  logic [4:0]           pass_count,
	input  logic [3:0]           clamp_pass,
	input  cmd_t                 q_head,
	input  logic                 q_valid,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 granted,
	output logic [3:0]           pass_index,
	output logic [TILE_BITS-1:0] start_tile,
	output logic [TILE_BITS-1:0] end_tile,
	output logic                 first_fine
);

	localparam int PW = $clog2(MAX_PASSES + 1);
	localparam int AW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
	localparam int DW = ((TILE_BITS > 8) ? TILE_BITS : 8) + 1;
	localparam int NW = (PW > 5) ? PW : 5;
	localparam int SW = ((DW > GROUP_BITS) ? DW : GROUP_BITS) + 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_READ = 5'b00100,
		ST_DIV1 = 5'b01000,
		ST_DIV2 = 5'b10000
	} state_t;

	state_t                state_q;
	logic [7:0]            tpg_q;
	logic [3:0]            coarse_q;
	logic [TILE_BITS-1:0]  left_q;
	logic [PW-1:0]         load_ptr_q;
	logic [GROUP_BITS-1:0] running_q;
	logic [GROUP_BITS-1:0] issued_q;
	logic [PW-1:0]         cur_pass_q;
	logic [TILE_BITS-1:0]  cur_tile_q;
	logic                  out_valid_q;
	logic                  granted_q;
	logic [3:0]            pass_idx_q;
	logic [TILE_BITS-1:0]  start_q;
	logic [TILE_BITS-1:0]  end_q;
	logic                  first_fine_q;

	logic                  take;
	logic [7:0]            tpg_in;
	logic [7:0]            tpg_rd;
	logic [7:0]            gt_rdata;
	logic [GROUP_BITS-1:0] end_rdata;
	logic [NW-1:0]         n_eff;
	logic [NW-1:0]         pc_ext;
	logic [NW-1:0]         cp_ext;
	logic [NW-1:0]         clamp_idx;
	logic                  lp_room;
	logic                  pass_in_table;
	logic [TILE_BITS-1:0]  left_now;
	logic                  refuse;
	logic [SW-1:0]         sum_wide;
	logic [GROUP_BITS-1:0] sum_sat;
	logic                  table_we;
	logic                  div_start;
	logic [DW-1:0]         div_dividend;
	logic [DW-1:0]         div_divisor;
	logic                  div_done;
	logic [DW-1:0]         div_quot;
	logic                  finish;
	logic                  fin_grant;
	logic [TILE_BITS-1:0]  fin_end;
	logic [PW+3:0]         pass_ext;
	logic [PW+3:0]         coarse_ext;

	// pass tables
	tgd_ram #(.WIDTH(8), .DEPTH(MAX_PASSES)) u_tpg_ram (
		.clk   (clk),
		.we    (table_we),
		.waddr (load_ptr_q[AW-1:0]),
		.wdata (tpg_q),
		.raddr (cur_pass_q[AW-1:0]),
		.rdata (gt_rdata)
	);

	tgd_ram #(.WIDTH(GROUP_BITS), .DEPTH(MAX_PASSES)) u_end_ram (
		.clk   (clk),
		.we    (table_we),
		.waddr (load_ptr_q[AW-1:0]),
		.wdata (sum_sat),
		.raddr (clamp_idx[AW-1:0]),
		.rdata (end_rdata)
	);

	tgd_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// clamp pass index: pass_count limited to 1..MAX_PASSES, clamp_pass to count-1
	always_comb begin
		pc_ext = NW'(pass_count);
		cp_ext = NW'(clamp_pass);
		if (pc_ext == '0) begin
			n_eff = NW'(1);
		end else if (pc_ext > NW'(MAX_PASSES)) begin
			n_eff = NW'(MAX_PASSES);
		end else begin
			n_eff = pc_ext;
		end
		clamp_idx = (cp_ext > n_eff - 1'b1) ? n_eff - 1'b1 : cp_ext;
	end

	// request-side decode
	assign take          = (state_q == ST_IDLE) && q_valid && !out_valid_q;
	assign q_pop         = take;
	assign tpg_in        = (q_head.group_tiles == '0) ? 8'd1 : q_head.group_tiles;
	assign lp_room       = load_ptr_q < PW'(MAX_PASSES);
	assign pass_in_table = cur_pass_q < PW'(MAX_PASSES);
	assign tpg_rd        = (!pass_in_table || gt_rdata == '0) ? 8'd1 : gt_rdata;
	assign left_now      = (cur_tile_q < tile_count) ? tile_count - cur_tile_q : '0;
	assign refuse        = issued_q >= end_rdata;
	assign pass_ext      = (PW+4)'(cur_pass_q);
	assign coarse_ext    = (PW+4)'(coarse_q);

	// group total with saturation
	always_comb begin
		sum_wide = SW'(running_q) + SW'(div_quot);
		sum_sat  = (sum_wide > SW'(GROUP_MAX)) ? GROUP_MAX : sum_wide[GROUP_BITS-1:0];
	end
	assign table_we = (state_q == ST_LOAD) && div_done;

	// divider operand select and completion
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DW'(tile_count) + DW'(tpg_in) - DW'(1);
		div_divisor  = DW'(tpg_in);
		finish       = 1'b0;
		fin_grant    = 1'b0;
		fin_end      = tile_count;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (q_head.op == OP_LOAD && lp_room) begin
						div_start = 1'b1;
					end else if (q_head.op != OP_REQUEST) begin
						finish = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				finish = div_done;
			end
			ST_READ: begin
				div_dividend = DW'(left_now) + DW'(tpg_rd) - DW'(1);
				div_divisor  = DW'(tpg_rd);
				if (refuse) begin
					finish = 1'b1;
				end else begin
					div_start = 1'b1;
				end
			end
			ST_DIV1: begin
				div_dividend = DW'(left_q);
				div_divisor  = div_quot;
				if (div_done) begin
					if (div_quot <= DW'(1)) begin
						finish    = 1'b1;
						fin_grant = 1'b1;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_DIV2: begin
				fin_end = cur_tile_q + div_quot[TILE_BITS-1:0];
				if (div_done) begin
					finish    = 1'b1;
					fin_grant = 1'b1;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// sequencer and dispatch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_ptr_q  <= '0;
			running_q   <= '0;
			issued_q    <= '0;
			cur_pass_q  <= '0;
			cur_tile_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (q_head.op)
							OP_LOAD: begin
								if (lp_room) begin
									state_q <= ST_LOAD;
								end
							end
							OP_RESTART: begin
								issued_q   <= '0;
								cur_pass_q <= '0;
								cur_tile_q <= '0;
							end
							OP_REQUEST: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LOAD: begin
					if (div_done) begin
						running_q  <= sum_sat;
						load_ptr_q <= load_ptr_q + 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (refuse) begin
						state_q <= ST_IDLE;
					end else begin
						issued_q <= issued_q + 1'b1;
						state_q  <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						if (div_quot <= DW'(1)) begin
							cur_tile_q <= '0;
							if (pass_in_table) begin
								cur_pass_q <= cur_pass_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIV2;
						end
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						cur_tile_q <= fin_end;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload and result register
	always_ff @(posedge clk) begin
		if (take) begin
			tpg_q    <= tpg_in;
			coarse_q <= q_head.coarse_pass;
		end
		if (state_q == ST_READ) begin
			left_q <= left_now;
		end
		if (finish) begin
			granted_q    <= fin_grant;
			pass_idx_q   <= fin_grant ? pass_ext[3:0] : 4'd0;
			start_q      <= fin_grant ? cur_tile_q : '0;
			end_q        <= fin_grant ? fin_end : '0;
			first_fine_q <= fin_grant && (cur_tile_q == '0) && (pass_ext == coarse_ext);
		end
	end

	assign out_valid  = out_valid_q;
	assign granted    = granted_q;
	assign pass_index = pass_idx_q;
	assign start_tile = start_q;
	assign end_tile   = end_q;
	assign first_fine = first_fine_q;

endmodule

FILE: design/tile_group_dispatcher.sv
// tile_group_dispatcher: one command beat in, one result beat out, in order.
// Request: up to two back-to-back passes of the bit-serial divider, DW = max(TILE_BITS,8)+1;
// a refused request ends after the table read, a load takes one divider pass, a restart none.
// A two-entry command queue keeps accepting beats, until it is full, while a result waits to be taken.
// Async active-low reset clears control state and the registers (tile_count 1,
// pass_count 1, clamp_pass 15); pass tables stay undefined until loaded, no clearing pass.
module tile_group_dispatcher import tgd_pkg::*; #(
	parameter int MAX_PASSES = MAX_PASSES_DEF,
	parameter int TILE_BITS  = TILE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [7:0]           group_tiles,
	input  logic [3:0]           coarse_pass,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 granted,
	output logic [3:0]           pass_index,
	output logic [TILE_BITS-1:0] start_tile,
	output logic [TILE_BITS-1:0] end_tile,
	output logic                 first_fine
);

	logic [TILE_BITS-1:0] tile_count_q;
	logic [4:0]           pass_count_q;
	logic [3:0]           clamp_pass_q;
	logic                 cfg_wr;
	cmd_t                 q_head;
	logic                 q_valid;
	logic                 q_pop;
	front_status_t        front_status;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_count_q <= TILE_BITS'(1);
			pass_count_q <= 5'd1;
			clamp_pass_q <= 4'd15;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TILE_COUNT: tile_count_q <= pwdata[TILE_BITS-1:0];
				REG_PASS_COUNT: pass_count_q <= pwdata[4:0];
				REG_CLAMP_PASS: clamp_pass_q <= pwdata[3:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TILE_COUNT: prdata = 32'(tile_count_q);
			REG_PASS_COUNT: prdata = 32'(pass_count_q);
			REG_CLAMP_PASS: prdata = 32'(clamp_pass_q);
			default:        prdata = '0;
		endcase
	end

	tgd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.group_tiles (group_tiles),
		.coarse_pass (coarse_pass),
		.q_head      (q_head),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.status      (front_status)
	);

	tgd_back #(
		.MAX_PASSES (MAX_PASSES),
		.TILE_BITS  (TILE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tile_count (tile_count_q),
		.pass_count (pass_count_q),
		.clamp_pass (clamp_pass_q),
		.q_head     (q_head),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.granted    (granted),
		.pass_index (pass_index),
		.start_tile (start_tile),
		.end_tile   (end_tile),
		.first_fine (first_fine)
	);

	// a refused or non-request beat carries an all-zero payload
	a_zero_when_not_granted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> pass_index == 4'd0 && start_tile == '0 &&
			end_tile == '0 && !first_fine)
		else $error("non-granted result with nonzero payload");

	// first_fine only on a granted group starting at tile zero
	a_first_fine_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_fine |-> granted && start_tile == '0)
		else $error("first_fine on a group not starting at tile zero");

	// a beat taken with no pop grows the queue by one
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !q_pop |=> front_status.count == $past(front_status.count) + 1'b1)
		else $error("command queue lost an accepted beat");

endmodule

FILE: tb/tb_tile_group_dispatcher.sv
// Self-checking testbench for tile_group_dispatcher: directed tests, then random dispatch phases.
// Predicts every result beat from its own copy of the pass tables and dispatch counters.
// Depends on tgd_pkg and the tile_group_dispatcher RTL only.
module tb_tile_group_dispatcher;
	import tgd_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;

	typedef struct {
		bit        granted;
		bit [3:0]  pass_index;
		bit [15:0] start_tile;
		bit [15:0] end_tile;
		bit        first_fine;
	} grant_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        command = CMD_NOP;
	logic [7:0]        group_tiles = '0;
	logic [3:0]        coarse_pass = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              granted;
	logic [3:0]        pass_index;
	logic [15:0]       start_tile;
	logic [15:0]       end_tile;
	logic              first_fine;

	tile_group_dispatcher dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .group_tiles(group_tiles), .coarse_pass(coarse_pass),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted(granted), .pass_index(pass_index), .start_tile(start_tile),
		.end_tile(end_tile), .first_fine(first_fine)
	);

	// clock, period 20
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted dispatcher state
	logic [15:0] cfg_tiles  = 16'd1;
	logic [4:0]  cfg_passes = 5'd1;
	logic [3:0]  cfg_clamp  = 4'd15;
	logic [7:0]  tpg_tab [MAX_PASSES_DEF];
	logic [GROUP_BITS-1:0] end_tab [MAX_PASSES_DEF];
	bit          loaded [MAX_PASSES_DEF];
	logic [4:0]  load_ptr = '0;
	logic [GROUP_BITS-1:0] run_total = '0;
	logic [GROUP_BITS-1:0] issued = '0;
	logic [4:0]  cur_pass = '0;
	logic [15:0] cur_tile = '0;

	grant_t due_results[$];
	grant_t head_result;
	int     errors = 0;
	int     rand_items = 0;
	bit     steady = 1'b0;
	bit     beyond_done = 1'b0;

	// pass table entry whose end group bounds dispatch
	function automatic logic [3:0] clamp_entry();
		int n;
		int p;
		n = cfg_passes;
		p = cfg_clamp;
		if (n == 0) n = 1;
		if (n > MAX_PASSES_DEF) n = MAX_PASSES_DEF;
		if (p > n - 1) p = n - 1;
		return p[3:0];
	endfunction

	// a request must never touch a table entry that was never loaded
	function automatic bit request_safe();
		logic [3:0] p;
		p = clamp_entry();
		if (!loaded[p]) return 1'b0;
		if (issued >= end_tab[p]) return 1'b1;
		if (cur_pass < MAX_PASSES_DEF && !loaded[cur_pass[3:0]]) return 1'b0;
		return 1'b1;
	endfunction

	// advance the predicted state by one accepted command and queue its result
	task automatic predict_dispatch(input logic [1:0] cmd, input logic [7:0] gt,
			input logic [3:0] coarse);
		grant_t r;
		int tpg;
		int sum;
		int start;
		int stop;
		int left;
		int groups_left;
		r = '{default: 0};
		case (cmd)
			CMD_LOAD: begin
				if (load_ptr < MAX_PASSES_DEF) begin
					tpg = (gt == 0) ? 1 : gt;
					sum = run_total + (int'(cfg_tiles) + tpg - 1) / tpg;
					if (sum > GROUP_MAX) sum = GROUP_MAX;
					run_total = GROUP_BITS'(sum);
					tpg_tab[load_ptr[3:0]] = 8'(tpg);
					end_tab[load_ptr[3:0]] = GROUP_BITS'(sum);
					loaded[load_ptr[3:0]] = 1'b1;
					load_ptr = load_ptr + 5'd1;
				end
			end
			CMD_RESTART: begin
				issued = '0;
				cur_pass = '0;
				cur_tile = '0;
			end
			CMD_REQUEST: begin
				if (issued < end_tab[clamp_entry()]) begin
					issued = issued + 1'b1;
					start = cur_tile;
					tpg = (cur_pass < MAX_PASSES_DEF) ? tpg_tab[cur_pass[3:0]] : 0;
					if (tpg == 0) tpg = 1;
					left = (start < cfg_tiles) ? cfg_tiles - start : 0;
					groups_left = (left + tpg - 1) / tpg;
					r.granted = 1'b1;
					r.pass_index = cur_pass[3:0];
					r.start_tile = 16'(start);
					r.first_fine = (start == 0 && cur_pass == {1'b0, coarse});
					if (groups_left <= 1) begin
						stop = cfg_tiles;
						cur_tile = '0;
						if (cur_pass < MAX_PASSES_DEF) cur_pass = cur_pass + 5'd1;
					end else begin
						stop = start + left / groups_left;
						cur_tile = 16'(stop);
					end
					r.end_tile = 16'(stop);
				end
			end
			default: ;
		endcase
		due_results.push_back(r);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// send one command beat, at times after a random gap unless steady is set
	task automatic issue_command(input logic [1:0] cmd, input logic [7:0] gt,
			input logic [3:0] coarse);
		int gap;
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		command <= cmd;
		group_tiles <= gt;
		coarse_pass <= coarse;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_dispatch(cmd, gt, coarse);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write, then read back the same register
	task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_TILE_COUNT: cfg_tiles = value[15:0];
			REG_PASS_COUNT: cfg_passes = value[4:0];
			REG_CLAMP_PASS: cfg_clamp = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("prdata", value, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_dispatch(input logic [15:0] tiles, input logic [4:0] passes,
			input logic [3:0] clamp);
		program_register(REG_TILE_COUNT, tiles);
		program_register(REG_PASS_COUNT, passes);
		program_register(REG_CLAMP_PASS, clamp);
	endtask

	// non-request commands straight after reset return an empty beat
	task automatic test_idle_commands();
		issue_command(CMD_NOP, 8'hFF, 4'hF);
		issue_command(CMD_RESTART, 8'h00, 4'h0);
	endtask

	// two passes, the second one balanced unevenly (5 tiles, 2 per group)
	task automatic test_load_and_dispatch();
		settle();
		set_dispatch(16'd5, 5'd2, 4'd15);
		issue_command(CMD_LOAD, 8'hFF, 4'h0);
		issue_command(CMD_LOAD, 8'd2, 4'h0);
		issue_command(CMD_RESTART, 8'd0, 4'd1);
		repeat (3) issue_command(CMD_REQUEST, 8'd0, 4'd1);
	endtask

	// tile count lowered below the current offset, then refusal at the clamp end group
	task automatic test_offset_past_end();
		settle();
		program_register(REG_TILE_COUNT, 16'd2);
		issue_command(CMD_REQUEST, 8'd0, 4'd1);
		issue_command(CMD_REQUEST, 8'd0, 4'd1);
	endtask

	// pass count below and above range, clamp at both ends
	task automatic test_clamp_limits();
		settle();
		set_dispatch(16'd2, 5'd0, 4'd0);
		issue_command(CMD_RESTART, 8'd0, 4'd0);
		issue_command(CMD_REQUEST, 8'd0, 4'd0);
		issue_command(CMD_REQUEST, 8'd0, 4'd0);
		settle();
		set_dispatch(16'hFFFF, 5'd31, 4'd1);
		issue_command(CMD_RESTART, 8'd0, 4'd0);
		issue_command(CMD_REQUEST, 8'd0, 4'd0);
		issue_command(CMD_REQUEST, 8'd0, 4'd15);
	endtask

	// random phases: new settings, a few pass loads, then a dispatch sweep
	task automatic test_random_dispatch();
		int phase;
		int nload;
		int nreq;
		int roll;
		int k;
		logic [15:0] tiles;
		logic [4:0]  passes;
		logic [3:0]  clamp;
		logic [1:0]  cmd;
		logic [7:0]  gt;
		logic [3:0]  coarse;
		bit          beyond;
		phase = 0;
		while (rand_items < 1180) begin
			settle();
			steady = (phase % 7 == 3);
			beyond = 1'b0;
			nload = 0;
			if (load_ptr < MAX_PASSES_DEF - 1)
				nload = $urandom_range(0, (MAX_PASSES_DEF - 1 - load_ptr) < 3 ?
					(MAX_PASSES_DEF - 1 - load_ptr) : 3);
			else if (load_ptr == MAX_PASSES_DEF - 1)
				nload = 1;

			// pick the phase settings
			roll = $urandom_range(0, 99);
			if (load_ptr == MAX_PASSES_DEF - 1)
				tiles = 16'hFFFF;
			else if (nload != 0)
				tiles = (roll < 5) ? 16'd0 : 16'($urandom_range(1, 300));
			else if (roll < 3)
				tiles = 16'd0;
			else if (roll < 8)
				tiles = 16'hFFFF;
			else if (roll < 18)
				tiles = 16'($urandom_range(1, 65535));
			else
				tiles = 16'($urandom_range(1, 300));
			if ($urandom_range(0, 99) < 30)
				passes = 5'($urandom_range(0, 31));
			else
				passes = 5'($urandom_range(1, (load_ptr == 0) ? 1 : load_ptr));
			clamp = 4'($urandom_range(0, 15));
			if (load_ptr == MAX_PASSES_DEF && !beyond_done) begin
				// walk past the last table entry
				tiles = 16'd1;
				passes = 5'd16;
				clamp = 4'd15;
				beyond = 1'b1;
				beyond_done = 1'b1;
			end
			set_dispatch(tiles, passes, clamp);

			// fill the pass table; the last entry gets the largest group count
			for (k = 0; k < nload; k++) begin
				if (load_ptr == MAX_PASSES_DEF - 1)
					gt = 8'd1;
				else if ($urandom_range(0, 9) == 0)
					gt = 8'($urandom_range(129, 255));
				else
					gt = 8'($urandom_range(0, 128));
				issue_command(CMD_LOAD, gt, 4'($urandom_range(0, 15)));
				rand_items++;
			end

			// dispatch sweep, mostly requests with some noise
			if (beyond || $urandom_range(0, 3) != 0) begin
				issue_command(CMD_RESTART, 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)));
				rand_items++;
			end
			nreq = beyond ? 24 : $urandom_range(1, 40);
			for (k = 0; k < nreq; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) cmd = CMD_REQUEST;
				else if (roll < 90) cmd = CMD_RESTART;
				else if (roll < 95) cmd = CMD_NOP;
				else cmd = (load_ptr == MAX_PASSES_DEF) ? CMD_LOAD : CMD_NOP;
				if (cmd == CMD_REQUEST && !request_safe()) cmd = CMD_RESTART;
				gt = 8'($urandom_range(0, 255));
				coarse = $urandom_range(0, 1) ? cur_pass[3:0] : 4'($urandom_range(0, 15));
				issue_command(cmd, gt, coarse);
				if (cmd == CMD_REQUEST || cmd == CMD_RESTART) rand_items++;
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	// receiver stalls at random outside steady phases
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 38);
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %0h %0h %0h %0h %0h",
					$time, granted, pass_index, start_tile, end_tile, first_fine);
			end else begin
				head_result = due_results.pop_front();
				check_field("granted", head_result.granted, granted);
				check_field("pass_index", head_result.pass_index, pass_index);
				check_field("start_tile", head_result.start_tile, start_tile);
				check_field("end_tile", head_result.end_tile, end_tile);
				check_field("first_fine", head_result.first_fine, first_fine);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_idle_commands();
		test_load_and_dispatch();
		test_offset_past_end();
		test_clamp_limits();
		test_random_dispatch();
		settle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** tile_group_dispatcher: PASSED **");
		else
			$display("** tile_group_dispatcher: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("** tile_group_dispatcher: FAILED **");
		$finish;
	end

endmodule
